FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Command and status codes, controller states and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_REM_HEAD = 3'd1,
        CMD_REM_ONE  = 3'd2,
        CMD_REM_ALL  = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
        logic largest_first;
    } t_cell_ctrl;

endpackage

FILE: src/spq_scan.sv
// ----------------------------------------------------------------------------
// spq_scan: prefix OR along the cell chain
// Gives, for every cell, whether a marked cell sits at or before it, and
// strictly before it. Log-depth tree of OR stages.
// ----------------------------------------------------------------------------
module spq_scan #(
    parameter int N = 16
) (
    input  logic [N-1:0] i_mark,
    output logic [N-1:0] o_incl,
    output logic [N-1:0] o_prev
);

    localparam int L = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] s [L+1];

    assign s[0] = i_mark;

    for (genvar k = 0; k < L; k++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign s[k+1][i] = s[k][i] | s[k][i - (1 << k)];
            end else begin : g_pass
                assign s[k+1][i] = s[k][i];
            end
        end
    end

    assign o_incl = s[L];
    assign o_prev = {s[L][N-2:0], 1'b0};

endmodule

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one key, compares it with the request key, and on an insert takes the
// request key or its left neighbour's key, or on a removal its right neighbour's.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                        i_clk,
    input  t_cell_ctrl                  i_ctrl,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    input  logic signed [KEY_WIDTH-1:0] i_left,
    input  logic signed [KEY_WIDTH-1:0] i_right,
    input  logic                        i_mark_incl,
    input  logic                        i_mark_prev,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_below,
    output logic                        o_eq
);

    logic signed [KEY_WIDTH-1:0] r_key;

    // held key ranks below the request key, so the new key goes in front
    assign o_below = i_ctrl.largest_first ? (r_key < i_key) : (i_key < r_key);
    assign o_eq    = (r_key == i_key);
    assign o_key   = r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (i_mark_incl && !i_mark_prev) begin
                r_key <= i_key;
            end else if (i_mark_prev) begin
                r_key <= i_left;
            end
        end else if (i_ctrl.rem && i_mark_incl) begin
            r_key <= i_right;
        end
    end

endmodule

FILE: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept sorted in a cell chain
// Insert, remove head, remove first match, remove a run of matches, clear.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  request   in         i_in_valid / o_in_stall     i_cmd, i_key
//  result    out        o_out_valid / i_out_stall   o_status, o_removed_count,
//                                                   o_head_key, o_head_valid,
//                                                   o_occupancy
//  config    in         i_cfg_wr_en                 i_cfg_wr_data
//
//  every cell compares and shifts in the same cycle; remove-all-matches
//  keeps the request channel stalled while the run is pulled out of the
//  chain one entry a cycle through the matched slot.
//  the result sits in an output register; a new request is taken while the
//  previous result is being taken. reset empties the queue and sets
//  largest-first order; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_cmd,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [$clog2(DEPTH+1)-1:0]  o_removed_count,
    output logic signed [KEY_WIDTH-1:0] o_head_key,
    output logic                        o_head_valid,
    output logic [$clog2(DEPTH+1)-1:0]  o_occupancy,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_lf;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [DEPTH-1:0]          r_pos_oh;
    logic [CNT_W-1:0]          r_run_removed;
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [CNT_W-1:0]          r_out_removed;

    t_cmd                      cmd;
    logic                      accept, full, empty, hit;
    logic                      run_start, run_hit, res_load;
    t_status                   res_status;
    logic [CNT_W-1:0]          res_removed;
    t_cell_ctrl                ctrl;
    logic signed [KEY_WIDTH-1:0] cmp_key;
    logic signed [KEY_WIDTH-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]          below_v, eq_v, valid_v, at_count;
    logic [DEPTH-1:0]          mark, mark_incl, mark_prev;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign cmp_key    = (r_state == S_RUN) ? r_key : i_key;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_v[i]  = (CNT_W'(i) < r_count);
            at_count[i] = (CNT_W'(i) == r_count);
        end
    end

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_WIDTH-1:0] left, right;
        if (g == 0) begin : g_first
            assign left = cmp_key;
        end else begin : g_mid_l
            assign left = cell_key[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = cell_key[g];
        end else begin : g_mid_r
            assign right = cell_key[g+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_key       (cmp_key),
            .i_left      (left),
            .i_right     (right),
            .i_mark_incl (mark_incl[g]),
            .i_mark_prev (mark_prev[g]),
            .o_key       (cell_key[g]),
            .o_below     (below_v[g]),
            .o_eq        (eq_v[g])
        );
    end

    // where the chain opens or closes: first marked slot
    always_comb begin
        mark = '0;
        if (r_state == S_RUN) begin
            mark = r_pos_oh & eq_v & valid_v;
        end else begin
            unique case (cmd)
                CMD_INSERT:               mark = (below_v & valid_v) | at_count;
                CMD_REM_HEAD:             mark = DEPTH'(1);
                CMD_REM_ONE, CMD_REM_ALL: mark = eq_v & valid_v;
                default:                  mark = '0;
            endcase
        end
    end

    spq_scan #(
        .N (DEPTH)
    ) u_scan (
        .i_mark (mark),
        .o_incl (mark_incl),
        .o_prev (mark_prev)
    );

    assign hit = mark_incl[DEPTH-1];

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (run_start) n_state = S_RUN;
            S_RUN:  if (!hit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl               = '0;
        ctrl.largest_first = r_lf;
        n_count            = r_count;
        res_status         = ST_OK;
        res_removed        = '0;
        res_load           = 1'b0;
        run_start          = 1'b0;
        run_hit            = 1'b0;
        if (r_state == S_RUN) begin
            if (hit) begin
                ctrl.rem = 1'b1;
                n_count  = r_count - CNT_W'(1);
                run_hit  = 1'b1;
            end else begin
                res_load    = 1'b1;
                res_removed = r_run_removed;
            end
        end else if (accept) begin
            unique case (cmd)
                CMD_INSERT: begin
                    res_load = 1'b1;
                    if (full) begin
                        res_status = ST_FULL;
                    end else begin
                        ctrl.ins = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_REM_HEAD: begin
                    res_load = 1'b1;
                    if (empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        ctrl.rem    = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        res_removed = CNT_W'(1);
                    end
                end
                CMD_REM_ONE, CMD_REM_ALL: begin
                    if (empty) begin
                        res_load   = 1'b1;
                        res_status = ST_EMPTY;
                    end else if (!hit) begin
                        res_load   = 1'b1;
                        res_status = ST_NOT_FOUND;
                    end else begin
                        ctrl.rem = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                        if (cmd == CMD_REM_ALL) begin
                            run_start = 1'b1;
                        end else begin
                            res_load    = 1'b1;
                            res_removed = CNT_W'(1);
                        end
                    end
                end
                CMD_CLEAR: begin
                    res_load    = 1'b1;
                    n_count     = '0;
                    res_removed = r_count;
                end
                default: res_load = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lf        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_lf <= i_cfg_wr_data;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key;
        end
        // matched slot stays put while the run slides into it
        if (run_start) begin
            r_pos_oh      <= mark_incl & ~mark_prev;
            r_run_removed <= CNT_W'(1);
        end else if (run_hit) begin
            r_run_removed <= r_run_removed + CNT_W'(1);
        end
        if (res_load) begin
            r_out_status  <= res_status;
            r_out_removed <= res_removed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_count = r_out_removed;
    assign o_occupancy     = r_count;
    assign o_head_valid    = !empty;
    assign o_head_key      = empty ? '0 : cell_key[0];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_run_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> $onehot(r_pos_oh))
        else $error("run position not one-hot");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_IDLE))
        else $error("result shown while a run is in progress");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_INSERT && !full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_occupancy == CNT_W'(DEPTH)))
        else $error("full reported below depth");

endmodule
